@@ sv/hsog_pkg.sv @@
// Shared types and constants for the Hilbert scan order generator.
`default_nettype none

package hsog_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_X_START = 2'd0,
        CFG_X_END   = 2'd1,
        CFG_Y_START = 2'd2,
        CFG_Y_END   = 2'd3
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic size;
        logic scale;
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_levels;
        logic step_last;
        logic in_bounds;
    } t_status;

endpackage

`default_nettype wire

@@ sv/hsog_ctrl.sv @@
// Controller state machine for the Hilbert scan order generator.
`default_nettype none

module hsog_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire             i_stall,
    input  hsog_pkg::t_status i_sts,
    output logic            o_stall,
    output logic            o_valid,
    output hsog_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SIZE  = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_sts.zero_levels ? S_CHECK : S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.in_bounds ? S_OUT : S_LOAD;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/hsog_dp.sv @@
// Datapath: window registers, curve walk one level per cycle, pixel counter.
`default_nettype none

module hsog_dp #(
    parameter int COORD_BITS = hsog_pkg::COORD_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [hsog_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire [COORD_BITS-1:0]               i_cfg_data,
    input  wire                                i_restart,
    input  hsog_pkg::t_cmd                     i_cmd,
    output hsog_pkg::t_status                  o_sts,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic                               o_last
);

    localparam int CB  = COORD_BITS;
    localparam int SZW = CB + 1;
    localparam int LW  = $clog2(CB + 1);
    localparam int IW  = 2 * CB;
    localparam int TW  = 2 * SZW;
    localparam int SW  = CB + 3;

    logic [CB-1:0]  r_x_start, r_x_end, r_y_start, r_y_end;
    logic [CB-1:0]  r_xe, r_ye;
    logic [SZW-1:0] r_xs, r_ys;
    logic [LW-1:0]  r_levels;
    logic [TW-1:0]  r_total;
    logic [IW-1:0]  r_index;
    logic [TW-1:0]  r_emitted;
    logic           r_finished;
    logic           r_restart;
    logic [IW-1:0]  r_k;
    logic [LW-1:0]  r_lv;
    logic signed [SW-1:0] r_ox, r_oy;
    logic signed [1:0]    r_dx, r_dy, r_px, r_py;
    logic [CB-1:0]  r_pix_x, r_pix_y;
    logic           r_last;

    logic [CB-1:0]  n_xe, n_ye;
    logic [SZW-1:0] size_max;
    logic [LW-1:0]  n_levels;
    logic [IW-1:0]  imask;
    logic [IW-1:0]  index_m;
    logic [LW-1:0]  lv_dec;
    logic [1:0]     quad;
    logic signed [SW-1:0] half, side;
    logic signed [SW-1:0] n_ox, n_oy;
    logic signed [1:0]    n_dx, n_dy, n_px, n_py;
    logic [TW-1:0]  n_emitted;

    function automatic logic signed [SW-1:0] dmul(input logic signed [1:0] d,
                                                  input logic signed [SW-1:0] v);
        logic signed [SW-1:0] res;
        case (d)
            2'sb01:  res = v;
            2'sb11:  res = -v;
            default: res = '0;
        endcase
        return res;
    endfunction

    // effective window ends and sides
    assign n_xe = (r_x_end < r_x_start) ? r_x_start : r_x_end;
    assign n_ye = (r_y_end < r_y_start) ? r_y_start : r_y_end;
    assign size_max = (r_xs > r_ys) ? r_xs : r_ys;

    always_comb begin
        n_levels = LW'(CB);
        for (int i = CB; i >= 0; i--) begin
            if ((SZW'(1) << i) >= size_max) begin
                n_levels = LW'(i);
            end
        end
    end

    assign imask   = (IW'(1) << (2 * r_levels)) - IW'(1);
    assign index_m = r_index & imask;

    // one curve level
    assign lv_dec = r_lv - LW'(1);
    assign quad   = 2'(r_k >> (2 * lv_dec));
    assign half   = SW'(1) << lv_dec;
    assign side   = SW'(1) << r_lv;

    always_comb begin
        n_ox = r_ox;
        n_oy = r_oy;
        n_dx = r_dx;
        n_dy = r_dy;
        n_px = r_px;
        n_py = r_py;
        case (quad)
            2'd0: begin
                n_dx = r_px;
                n_dy = r_py;
                n_px = r_dx;
                n_py = r_dy;
            end
            2'd1: begin
                n_ox = r_ox + dmul(r_px, half);
                n_oy = r_oy + dmul(r_py, half);
            end
            2'd2: begin
                n_ox = r_ox + dmul(r_px, half) + dmul(r_dx, half);
                n_oy = r_oy + dmul(r_py, half) + dmul(r_dy, half);
            end
            default: begin
                n_ox = r_ox + dmul(r_px, half - SW'(1)) + dmul(r_dx, side - SW'(1));
                n_oy = r_oy + dmul(r_py, half - SW'(1)) + dmul(r_dy, side - SW'(1));
                n_dx = -r_px;
                n_dy = -r_py;
                n_px = -r_dx;
                n_py = -r_dy;
            end
        endcase
    end

    assign n_emitted = ((r_k == '0) ? TW'(0) : r_emitted) + TW'(1);

    assign o_sts.zero_levels = (r_levels == '0);
    assign o_sts.step_last   = (r_lv == LW'(1));
    assign o_sts.in_bounds   = (r_ox <= $signed(SW'(r_xe))) && (r_oy <= $signed(SW'(r_ye)));

    // control-relevant state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start  <= '0;
            r_x_end    <= '0;
            r_y_start  <= '0;
            r_y_end    <= '0;
            r_index    <= '0;
            r_emitted  <= '0;
            r_finished <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (hsog_pkg::t_cfg_idx'(i_cfg_idx))
                    hsog_pkg::CFG_X_START: r_x_start <= i_cfg_data;
                    hsog_pkg::CFG_X_END:   r_x_end   <= i_cfg_data;
                    hsog_pkg::CFG_Y_START: r_y_start <= i_cfg_data;
                    hsog_pkg::CFG_Y_END:   r_y_end   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.scale && (r_restart || r_finished)) begin
                r_index    <= '0;
                r_emitted  <= '0;
                r_finished <= 1'b0;
            end
            if (i_cmd.load) begin
                r_index <= (index_m + IW'(1)) & imask;
            end
            if (i_cmd.emit) begin
                r_emitted  <= n_emitted;
                r_finished <= (n_emitted >= r_total);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_restart <= i_restart;
        end
        if (i_cmd.size) begin
            r_xe <= n_xe;
            r_ye <= n_ye;
            r_xs <= SZW'(n_xe - r_x_start) + SZW'(1);
            r_ys <= SZW'(n_ye - r_y_start) + SZW'(1);
        end
        if (i_cmd.scale) begin
            r_levels <= n_levels;
            r_total  <= r_xs * r_ys;
        end
        if (i_cmd.load) begin
            r_k  <= index_m;
            r_lv <= r_levels;
            r_ox <= SW'(r_x_start);
            r_oy <= SW'(r_y_start);
            r_dx <= 2'sb00;
            r_dy <= 2'sb01;
            r_px <= 2'sb01;
            r_py <= 2'sb00;
        end
        if (i_cmd.step) begin
            r_lv <= lv_dec;
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_px <= n_px;
            r_py <= n_py;
        end
        if (i_cmd.emit) begin
            r_pix_x <= r_ox[CB-1:0];
            r_pix_y <= r_oy[CB-1:0];
            r_last  <= (n_emitted >= r_total);
        end
    end

    assign o_pixel_x = r_pix_x;
    assign o_pixel_y = r_pix_y;
    assign o_last    = r_last;

endmodule

`default_nettype wire

@@ sv/hilbert_scan_order_generator.sv @@
// Top level of the Hilbert scan order generator.
//
// Each request on the input channel (i_valid / o_stall, payload i_restart)
// yields one pixel on the output channel (o_valid / i_stall, payload
// o_pixel_x, o_pixel_y, o_last). Pixels of the window set by the four
// configuration registers come out in Hilbert-curve order; o_last marks the
// final pixel, and the next request then starts again at the start corner.
// i_restart rewinds to the start corner before the pixel is produced.
// The curve point is built one level per cycle, L levels, L = log2 of the
// curve side. The pixel is written once a curve point lies in the window;
// each point outside it is skipped and the next one is built. A new
// request is taken in the cycle after the pixel is written.
// One request is in work at a time; o_stall is high from acceptance until
// the pixel is placed in the output register. The output register holds the
// pixel while i_stall is high; a new request is taken meanwhile and waits to
// write its pixel until that one is taken.
// Reset (synchronous, active low) clears the configuration registers and
// rewinds the scan. Configuration writes are taken any cycle and belong
// where no request is outstanding.
`default_nettype none

module hilbert_scan_order_generator #(
    parameter int COORD_BITS = hsog_pkg::COORD_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [hsog_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire [COORD_BITS-1:0]             i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_restart,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [COORD_BITS-1:0]            o_pixel_x,
    output logic [COORD_BITS-1:0]            o_pixel_y,
    output logic                             o_last
);

    hsog_pkg::t_cmd    w_cmd;
    hsog_pkg::t_status w_sts;

    hsog_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    hsog_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_restart  (i_restart),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y),
        .o_last     (o_last)
    );

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted but block not busy");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.emit))
        else $error("output valid without a pixel write");

    a_emit_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.in_bounds)
        else $error("pixel written outside the window");

endmodule

`default_nettype wire

@@ verif/tb_hilbert_scan_order_generator.sv @@
// Testbench for the Hilbert scan order generator: directed and random windows.
`default_nettype none

module tb_hilbert_scan_order_generator;

    localparam int CW        = hsog_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX = (1 << CW) - 1;

    typedef logic [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY} t_rx_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    hsog_pkg::t_cfg_idx i_cfg_idx;
    t_coord             i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic               i_restart;
    logic               o_valid;
    logic               i_stall;
    t_coord             o_pixel_x;
    t_coord             o_pixel_y;
    logic               o_last;

    // predictor copy of the window and scan position
    t_coord   win_x_lo, win_x_hi, win_y_lo, win_y_hi;
    longint   curve_pos;
    longint   pixels_given;
    bit       scan_complete;

    bit       pending_restarts[$];
    t_pixel   expected_pixels[$];
    t_pixel   head_pixel;
    int       fail_count = 0;

    int       burst_left = 1;
    int       gap_left = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       mode_left = 0;
    int       run_left = 0;
    bit       run_held = 1'b0;

    hilbert_scan_order_generator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_restart  (i_restart),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y),
        .o_last     (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clamp_hi(input t_coord lo, input t_coord hi);
        return (hi < lo) ? longint'(lo) : longint'(hi);
    endfunction

    function automatic int curve_levels();
        longint w, h, side;
        int     lv;
        w = clamp_hi(win_x_lo, win_x_hi) - win_x_lo + 1;
        h = clamp_hi(win_y_lo, win_y_hi) - win_y_lo + 1;
        side = (w > h) ? w : h;
        lv = 0;
        while ((longint'(1) << lv) < side && lv < CW)
            lv++;
        return lv;
    endfunction

    function automatic void hilbert_xy(input longint idx, input int levels,
                                       output longint ox, output longint oy);
        longint dx, dy, px, py, t, s, h;
        longint ndx, ndy, npx, npy;
        int     lv, q;
        ox = win_x_lo;
        oy = win_y_lo;
        dx = 0; dy = 1; px = 1; py = 0;
        s = longint'(1) << levels;
        lv = levels;
        while (lv > 0) begin
            h = s >>> 1;
            lv--;
            q = int'((idx >> (2 * lv)) & 3);
            case (q)
                0: begin
                    t = dx; dx = px; px = t;
                    t = dy; dy = py; py = t;
                end
                1: begin
                    ox += px * h;
                    oy += py * h;
                end
                2: begin
                    ox += (px + dx) * h;
                    oy += (py + dy) * h;
                end
                default: begin
                    ndx = -px; ndy = -py; npx = -dx; npy = -dy;
                    ox += px * (h - 1) + dx * (s - 1);
                    oy += py * (h - 1) + dy * (s - 1);
                    dx = ndx; dy = ndy; px = npx; py = npy;
                end
            endcase
            s = h;
        end
    endfunction

    function automatic t_pixel next_scan_pixel(input bit rewind);
        int     levels;
        longint lap_mask, x_hi, y_hi, total, k, cx, cy;
        bit     hit;
        t_pixel r;
        levels = curve_levels();
        lap_mask = (longint'(1) << (2 * levels)) - 1;
        x_hi = clamp_hi(win_x_lo, win_x_hi);
        y_hi = clamp_hi(win_y_lo, win_y_hi);
        total = (x_hi - win_x_lo + 1) * (y_hi - win_y_lo + 1);
        if (rewind || scan_complete) begin
            curve_pos = 0;
            pixels_given = 0;
            scan_complete = 1'b0;
        end
        curve_pos &= lap_mask;
        // the start corner is always inside, so this ends within one lap
        hit = 1'b0;
        k = 0; cx = 0; cy = 0;
        while (!hit) begin
            k = curve_pos;
            hilbert_xy(k, levels, cx, cy);
            curve_pos = (curve_pos + 1) & lap_mask;
            hit = (cx <= x_hi) && (cy <= y_hi);
        end
        if (k == 0)
            pixels_given = 0;
        pixels_given++;
        r.last = (pixels_given >= total);
        scan_complete = r.last;
        r.x = cx[CW-1:0];
        r.y = cy[CW-1:0];
        return r;
    endfunction

    function automatic t_coord pick_start();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return t_coord'(COORD_MAX - $urandom_range(0, 20));
            default: return t_coord'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    function automatic t_coord pick_end(input t_coord lo);
        int span;
        if (lo != 0 && $urandom_range(0, 9) == 0)
            return t_coord'($urandom_range(0, lo - 1));
        span = ($urandom_range(0, 11) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 15);
        return (int'(lo) + span > COORD_MAX) ? t_coord'(COORD_MAX) : t_coord'(lo + span);
    endfunction

    task automatic write_reg(input hsog_pkg::t_cfg_idx idx, input t_coord value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            hsog_pkg::CFG_X_START: win_x_lo = value;
            hsog_pkg::CFG_X_END:   win_x_hi = value;
            hsog_pkg::CFG_Y_START: win_y_lo = value;
            default:               win_y_hi = value;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(input t_coord xs, input t_coord xe,
                              input t_coord ys, input t_coord ye);
        write_reg(hsog_pkg::CFG_X_START, xs);
        write_reg(hsog_pkg::CFG_X_END, xe);
        write_reg(hsog_pkg::CFG_Y_START, ys);
        write_reg(hsog_pkg::CFG_Y_END, ye);
    endtask

    task automatic queue_requests(input int count, input logic [7:0] rewinds);
        @(negedge i_clk);
        for (int i = 0; i < count; i++)
            pending_restarts.insert(pending_restarts.size(), rewinds[i]);
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_restarts.size() != 0 || i_valid || expected_pixels.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_pixels.insert(expected_pixels.size(), next_scan_pixel(i_restart));
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_restarts.size() != 0) begin
                    i_valid   <= 1'b1;
                    i_restart <= pending_restarts.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel x=%0d y=%0d last=%0d", o_pixel_x, o_pixel_y, o_last);
                    fail_count++;
                end else begin
                    head_pixel = expected_pixels.pop_front();
                    if (o_pixel_x !== head_pixel.x) begin
                        $error("pixel_x mismatch: expected %0d, got %0d", head_pixel.x, o_pixel_x);
                        fail_count++;
                    end
                    if (o_pixel_y !== head_pixel.y) begin
                        $error("pixel_y mismatch: expected %0d, got %0d", head_pixel.y, o_pixel_y);
                        fail_count++;
                    end
                    if (o_last !== head_pixel.last) begin
                        $error("last mismatch: expected %0d, got %0d", head_pixel.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                default: begin
                    if (run_left == 0) begin
                        run_held = !run_held;
                        run_left = $urandom_range(1, 12);
                    end else begin
                        run_left--;
                    end
                    i_stall <= run_held;
                end
            endcase
        end
    end

    initial begin
        int     n, sent;
        t_coord xs, ys;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = hsog_pkg::CFG_X_START;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_restart  = 1'b0;
        i_stall    = 1'b0;
        win_x_lo = '0; win_x_hi = '0; win_y_lo = '0; win_y_hi = '0;
        curve_pos = 0;
        pixels_given = 0;
        scan_complete = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window is a single pixel: every request is the last one
        queue_requests(2, 8'b10);
        wait_drained();
        // window at the top corner; curve points past 4095 must be skipped
        set_window(t_coord'(4090), t_coord'(COORD_MAX), t_coord'(4090), t_coord'(COORD_MAX));
        queue_requests(3, 8'b100);
        wait_drained();
        // full coordinate range, deepest curve
        set_window('0, t_coord'(COORD_MAX), '0, t_coord'(COORD_MAX));
        queue_requests(4, 8'b1000);
        wait_drained();
        // inverted x range collapses to one column at the far edge
        set_window(t_coord'(COORD_MAX), '0, t_coord'(5), t_coord'(7));
        queue_requests(4, 8'b0);
        wait_drained();
        // window shrinks in the middle of a scan
        set_window(t_coord'(10), t_coord'(12), t_coord'(20), t_coord'(21));
        queue_requests(3, 8'b0);
        wait_drained();
        write_reg(hsog_pkg::CFG_X_END, t_coord'(11));
        queue_requests(3, 8'b0);
        wait_drained();
        write_reg(hsog_pkg::CFG_X_END, t_coord'(10));
        write_reg(hsog_pkg::CFG_Y_END, t_coord'(20));
        queue_requests(2, 8'b0);

        sent = 0;
        while (sent < 1900) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0, 1: begin
                    xs = pick_start();
                    ys = pick_start();
                    set_window(xs, pick_end(xs), ys, pick_end(ys));
                end
                2: write_reg(hsog_pkg::CFG_X_END, pick_end(win_x_lo));
                default: write_reg(hsog_pkg::CFG_Y_END, pick_end(win_y_lo));
            endcase
            n = $urandom_range(1, 80);
            @(negedge i_clk);
            repeat (n)
                pending_restarts.insert(pending_restarts.size(), $urandom_range(0, 11) == 0);
            sent += n;
        end
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
